@@ hdl/datalog_token_lexer_top_assert.svh @@
// assertion macros for the token lexer
`ifndef DATALOG_TOKEN_LEXER_TOP_ASSERT_SVH
`define DATALOG_TOKEN_LEXER_TOP_ASSERT_SVH

// same-cycle implication
`define DTL_ASSERT_IMPL(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
		else $error("token lexer assertion failed");

// next-cycle implication
`define DTL_ASSERT_NEXT(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
		else $error("token lexer assertion failed");

`endif

@@ hdl/dtl_pkg.sv @@
`default_nettype none

package dtl_pkg;

	localparam int unsigned LINE_BITS_DEF = 20;
	localparam int unsigned POS_BITS_DEF  = 24;
	localparam int unsigned LEN_BITS_DEF  = 16;

	localparam int unsigned Q_DEPTH = 8;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam int unsigned MAX_RES = 3;

	typedef enum logic [3:0] {
		M_IDLE,
		M_COLON,
		M_IDENT,
		M_STR,
		M_STRQ,
		M_HASH,
		M_LINE,
		M_BLOCK,
		M_BAR
	} lex_mode_t;

	typedef enum logic [4:0] {
		K_COMMA,
		K_PERIOD,
		K_QMARK,
		K_LPAREN,
		K_RPAREN,
		K_COLON,
		K_COLONDASH,
		K_MUL,
		K_ADD,
		K_SCHEMES,
		K_FACTS,
		K_RULES,
		K_QUERIES,
		K_ID,
		K_STRING,
		K_COMMENT,
		K_UNDEF,
		K_EOF
	} tok_kind_t;

	localparam logic [2:0] KC_NONE    = 3'd0;
	localparam logic [2:0] KC_SCHEMES = 3'd1;
	localparam logic [2:0] KC_FACTS   = 3'd2;
	localparam logic [2:0] KC_RULES   = 3'd3;
	localparam logic [2:0] KC_QUERIES = 3'd4;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_UP_S   = 8'h53;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_UP_R   = 8'h52;
	localparam logic [7:0] CH_UP_Q   = 8'h51;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic [3:0] kw_len(input logic [2:0] cand);
		logic [3:0] n;
		case (cand)
			KC_SCHEMES: n = 4'd7;
			KC_FACTS:   n = 4'd5;
			KC_RULES:   n = 4'd5;
			KC_QUERIES: n = 4'd7;
			default:    n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] cand, input logic [3:0] idx);
		logic [55:0] txt;
		logic [7:0]  ch;
		case (cand)
			KC_SCHEMES: txt = "Schemes";
			KC_FACTS:   txt = {"Facts", 16'h0000};
			KC_RULES:   txt = {"Rules", 16'h0000};
			KC_QUERIES: txt = "Queries";
			default:    txt = '0;
		endcase
		ch = 8'h00;
		for (int i = 0; i < 7; i++) begin
			if (idx == 4'(i)) begin
				ch = txt[8 * (6 - i) +: 8];
			end
		end
		return ch;
	endfunction

	function automatic tok_kind_t ident_kind(input logic [2:0] cand, input logic [3:0] idx);
		tok_kind_t k;
		k = K_ID;
		if (kw_len(cand) != 4'd0 && idx == kw_len(cand)) begin
			case (cand)
				KC_SCHEMES: k = K_SCHEMES;
				KC_FACTS:   k = K_FACTS;
				KC_RULES:   k = K_RULES;
				KC_QUERIES: k = K_QUERIES;
				default:    k = K_ID;
			endcase
		end
		return k;
	endfunction

endpackage

`default_nettype wire

@@ hdl/datalog_token_lexer_top.sv @@
// Datalog token lexer. One character is taken per cycle; its state update
// (mode, line and position counters, token start, length and keyword
// match) is done in the cycle it is accepted, and the zero to three token
// descriptors it produces are written at once into an 8-entry result queue
// that delivers one descriptor per cycle while out_stall is low. The input
// stalls while fewer than three queue slots are free, so the block
// sustains one character per cycle as long as the text averages no more
// than one token per character; a burst of multi-token characters is
// limited by the one-per-cycle drain of the queue. Results leave from the
// registered queue, behind earlier descriptors. After the end-of-file token
// the lexer state is back at its reset values, ready for a new text.
`default_nettype none

module datalog_token_lexer_top #(
	parameter int unsigned LINE_BITS = dtl_pkg::LINE_BITS_DEF,
	parameter int unsigned POS_BITS  = dtl_pkg::POS_BITS_DEF,
	parameter int unsigned LEN_BITS  = dtl_pkg::LEN_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           char_code,
	input  wire logic                 is_last,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [4:0]                token_kind,
	output logic [LINE_BITS-1:0]      start_line,
	output logic [POS_BITS-1:0]       start_pos,
	output logic [LEN_BITS-1:0]       token_length,
	output logic                      last_token
);

	`include "datalog_token_lexer_top_assert.svh"

	localparam int unsigned PW = dtl_pkg::Q_PTR_W;
	localparam int unsigned CW = dtl_pkg::Q_CNT_W;
	localparam int unsigned NE = dtl_pkg::MAX_RES + 1;

	dtl_pkg::lex_mode_t   mode_q, n_mode;
	logic [LINE_BITS-1:0] line_q, n_line, line_nx;
	logic [POS_BITS-1:0]  pos_q, n_pos, pos_nx;
	logic [LINE_BITS-1:0] tsl_q, n_tsl;
	logic [POS_BITS-1:0]  tsp_q, n_tsp;
	logic [LEN_BITS-1:0]  tlen_q, n_tlen, tlen_inc;
	logic [2:0]           kc_q, n_kc;
	logic [3:0]           ki_q, n_ki;
	logic                 run_idle;

	logic                 ev    [NE];
	dtl_pkg::tok_kind_t   ek    [NE];
	logic [LINE_BITS-1:0] el    [NE];
	logic [POS_BITS-1:0]  ep    [NE];
	logic [LEN_BITS-1:0]  elen  [NE];
	logic                 elast [NE];

	logic [4:0]           mem_kind [dtl_pkg::Q_DEPTH];
	logic [LINE_BITS-1:0] mem_line [dtl_pkg::Q_DEPTH];
	logic [POS_BITS-1:0]  mem_pos  [dtl_pkg::Q_DEPTH];
	logic [LEN_BITS-1:0]  mem_len  [dtl_pkg::Q_DEPTH];
	logic                 mem_last [dtl_pkg::Q_DEPTH];

	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]        cnt_q;
	logic [PW-1:0]        slot [NE];
	logic                 we   [NE];
	logic [2:0]           push_n;
	logic                 in_acc, pop;

	assign in_acc    = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;
	assign in_stall  = cnt_q > CW'(dtl_pkg::Q_DEPTH - dtl_pkg::MAX_RES);
	assign out_valid = cnt_q != '0;
	assign tlen_inc  = (&tlen_q) ? tlen_q : LEN_BITS'(tlen_q + LEN_BITS'(1));

	always_comb begin
		n_mode   = mode_q;
		n_tsl    = tsl_q;
		n_tsp    = tsp_q;
		n_tlen   = tlen_q;
		n_kc     = kc_q;
		n_ki     = ki_q;
		run_idle = 1'b0;
		for (int i = 0; i < NE; i++) begin
			ev[i]    = 1'b0;
			ek[i]    = dtl_pkg::K_UNDEF;
			el[i]    = tsl_q;
			ep[i]    = tsp_q;
			elen[i]  = tlen_q;
			elast[i] = 1'b0;
		end

		// finish or extend the pending token
		unique case (mode_q)
			dtl_pkg::M_COLON: begin
				n_mode = dtl_pkg::M_IDLE;
				ev[0]  = 1'b1;
				if (char_code == dtl_pkg::CH_DASH) begin
					n_tlen  = tlen_inc;
					ek[0]   = dtl_pkg::K_COLONDASH;
					elen[0] = tlen_inc;
				end else begin
					ek[0]    = dtl_pkg::K_COLON;
					run_idle = 1'b1;
				end
			end
			dtl_pkg::M_IDENT: begin
				if (dtl_pkg::is_alnum(char_code)) begin
					n_tlen = tlen_inc;
					if (ki_q < dtl_pkg::kw_len(kc_q) &&
					    dtl_pkg::kw_char(kc_q, ki_q) == char_code) begin
						n_ki = ki_q + 4'd1;
					end else begin
						n_kc = dtl_pkg::KC_NONE;
						n_ki = 4'd0;
					end
				end else begin
					ev[0]    = 1'b1;
					ek[0]    = dtl_pkg::ident_kind(kc_q, ki_q);
					n_kc     = dtl_pkg::KC_NONE;
					n_ki     = 4'd0;
					n_mode   = dtl_pkg::M_IDLE;
					run_idle = 1'b1;
				end
			end
			dtl_pkg::M_STR: begin
				n_tlen = tlen_inc;
				if (char_code == dtl_pkg::CH_QUOTE) begin
					n_mode = dtl_pkg::M_STRQ;
				end
			end
			dtl_pkg::M_STRQ: begin
				if (char_code == dtl_pkg::CH_QUOTE) begin
					n_tlen = tlen_inc;
					n_mode = dtl_pkg::M_STR;
				end else begin
					ev[0]    = 1'b1;
					ek[0]    = dtl_pkg::K_STRING;
					n_mode   = dtl_pkg::M_IDLE;
					run_idle = 1'b1;
				end
			end
			dtl_pkg::M_HASH: begin
				if (char_code == dtl_pkg::CH_BAR) begin
					n_tlen = tlen_inc;
					n_mode = dtl_pkg::M_BLOCK;
				end else if (char_code == dtl_pkg::CH_NL) begin
					ev[0]    = 1'b1;
					ek[0]    = dtl_pkg::K_COMMENT;
					n_mode   = dtl_pkg::M_IDLE;
					run_idle = 1'b1;
				end else begin
					n_tlen = tlen_inc;
					n_mode = dtl_pkg::M_LINE;
				end
			end
			dtl_pkg::M_LINE: begin
				if (char_code == dtl_pkg::CH_NL) begin
					ev[0]    = 1'b1;
					ek[0]    = dtl_pkg::K_COMMENT;
					n_mode   = dtl_pkg::M_IDLE;
					run_idle = 1'b1;
				end else begin
					n_tlen = tlen_inc;
				end
			end
			dtl_pkg::M_BLOCK: begin
				n_tlen = tlen_inc;
				if (char_code == dtl_pkg::CH_BAR) begin
					n_mode = dtl_pkg::M_BAR;
				end
			end
			dtl_pkg::M_BAR: begin
				n_tlen = tlen_inc;
				if (char_code == dtl_pkg::CH_HASH) begin
					ev[0]  = 1'b1;
					ek[0]  = dtl_pkg::K_COMMENT;
					elen[0] = tlen_inc;
					n_mode = dtl_pkg::M_IDLE;
				end else if (char_code != dtl_pkg::CH_BAR) begin
					n_mode = dtl_pkg::M_BLOCK;
				end
			end
			default: begin
				n_mode   = dtl_pkg::M_IDLE;
				run_idle = 1'b1;
			end
		endcase

		// take the character as a fresh one
		if (run_idle) begin
			el[1]   = line_q;
			ep[1]   = pos_q;
			elen[1] = LEN_BITS'(1);
			case (char_code) inside
				dtl_pkg::CH_SPACE, dtl_pkg::CH_NL: begin
				end
				dtl_pkg::CH_COMMA: begin
					ev[1] = 1'b1;
					ek[1] = dtl_pkg::K_COMMA;
				end
				dtl_pkg::CH_PERIOD: begin
					ev[1] = 1'b1;
					ek[1] = dtl_pkg::K_PERIOD;
				end
				dtl_pkg::CH_QMARK: begin
					ev[1] = 1'b1;
					ek[1] = dtl_pkg::K_QMARK;
				end
				dtl_pkg::CH_LPAREN: begin
					ev[1] = 1'b1;
					ek[1] = dtl_pkg::K_LPAREN;
				end
				dtl_pkg::CH_RPAREN: begin
					ev[1] = 1'b1;
					ek[1] = dtl_pkg::K_RPAREN;
				end
				dtl_pkg::CH_STAR: begin
					ev[1] = 1'b1;
					ek[1] = dtl_pkg::K_MUL;
				end
				dtl_pkg::CH_PLUS: begin
					ev[1] = 1'b1;
					ek[1] = dtl_pkg::K_ADD;
				end
				dtl_pkg::CH_COLON, dtl_pkg::CH_QUOTE, dtl_pkg::CH_HASH: begin
					n_tsl  = line_q;
					n_tsp  = pos_q;
					n_tlen = LEN_BITS'(1);
					if (char_code == dtl_pkg::CH_COLON) begin
						n_mode = dtl_pkg::M_COLON;
					end else if (char_code == dtl_pkg::CH_QUOTE) begin
						n_mode = dtl_pkg::M_STR;
					end else begin
						n_mode = dtl_pkg::M_HASH;
					end
				end
				default: begin
					if (dtl_pkg::is_alpha(char_code)) begin
						n_tsl  = line_q;
						n_tsp  = pos_q;
						n_tlen = LEN_BITS'(1);
						n_mode = dtl_pkg::M_IDENT;
						n_ki   = 4'd1;
						if (char_code == dtl_pkg::CH_UP_S) begin
							n_kc = dtl_pkg::KC_SCHEMES;
						end else if (char_code == dtl_pkg::CH_UP_F) begin
							n_kc = dtl_pkg::KC_FACTS;
						end else if (char_code == dtl_pkg::CH_UP_R) begin
							n_kc = dtl_pkg::KC_RULES;
						end else if (char_code == dtl_pkg::CH_UP_Q) begin
							n_kc = dtl_pkg::KC_QUERIES;
						end else begin
							n_kc = dtl_pkg::KC_NONE;
							n_ki = 4'd0;
						end
					end else begin
						ev[1] = 1'b1;
						ek[1] = dtl_pkg::K_UNDEF;
					end
				end
			endcase
		end

		line_nx = (char_code == dtl_pkg::CH_NL && !(&line_q)) ?
			LINE_BITS'(line_q + LINE_BITS'(1)) : line_q;
		pos_nx  = (&pos_q) ? pos_q : POS_BITS'(pos_q + POS_BITS'(1));
		n_line  = line_nx;
		n_pos   = pos_nx;

		// flush at end of text, then end-of-file, then back to reset
		if (is_last) begin
			el[2]   = n_tsl;
			ep[2]   = n_tsp;
			elen[2] = n_tlen;
			case (n_mode)
				dtl_pkg::M_COLON: begin
					ev[2] = 1'b1;
					ek[2] = dtl_pkg::K_COLON;
				end
				dtl_pkg::M_IDENT: begin
					ev[2] = 1'b1;
					ek[2] = dtl_pkg::ident_kind(n_kc, n_ki);
				end
				dtl_pkg::M_STRQ: begin
					ev[2] = 1'b1;
					ek[2] = dtl_pkg::K_STRING;
				end
				dtl_pkg::M_HASH, dtl_pkg::M_LINE: begin
					ev[2] = 1'b1;
					ek[2] = dtl_pkg::K_COMMENT;
				end
				dtl_pkg::M_STR, dtl_pkg::M_BLOCK, dtl_pkg::M_BAR: begin
					ev[2] = 1'b1;
					ek[2] = dtl_pkg::K_UNDEF;
				end
				default: begin
				end
			endcase
			ev[3]    = 1'b1;
			ek[3]    = dtl_pkg::K_EOF;
			el[3]    = line_nx;
			ep[3]    = pos_nx;
			elen[3]  = '0;
			elast[3] = 1'b1;
			n_mode   = dtl_pkg::M_IDLE;
			n_line   = LINE_BITS'(1);
			n_pos    = '0;
			n_tsl    = LINE_BITS'(1);
			n_tsp    = '0;
			n_tlen   = '0;
			n_kc     = dtl_pkg::KC_NONE;
			n_ki     = 4'd0;
		end
	end

	// pack valid results into consecutive queue slots
	always_comb begin
		push_n = 3'd0;
		for (int i = 0; i < NE; i++) begin
			slot[i] = wr_ptr_q + PW'(push_n);
			we[i]   = ev[i] && in_acc;
			push_n  = push_n + {2'b00, ev[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= dtl_pkg::M_IDLE;
			line_q   <= LINE_BITS'(1);
			pos_q    <= '0;
			tsl_q    <= LINE_BITS'(1);
			tsp_q    <= '0;
			tlen_q   <= '0;
			kc_q     <= dtl_pkg::KC_NONE;
			ki_q     <= 4'd0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_acc) begin
				mode_q   <= n_mode;
				line_q   <= n_line;
				pos_q    <= n_pos;
				tsl_q    <= n_tsl;
				tsp_q    <= n_tsp;
				tlen_q   <= n_tlen;
				kc_q     <= n_kc;
				ki_q     <= n_ki;
				wr_ptr_q <= wr_ptr_q + PW'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (in_acc ? CW'(push_n) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NE; i++) begin
			if (we[i]) begin
				mem_kind[slot[i]] <= ek[i];
				mem_line[slot[i]] <= el[i];
				mem_pos[slot[i]]  <= ep[i];
				mem_len[slot[i]]  <= elen[i];
				mem_last[slot[i]] <= elast[i];
			end
		end
	end

	assign token_kind   = mem_kind[rd_ptr_q];
	assign start_line   = mem_line[rd_ptr_q];
	assign start_pos    = mem_pos[rd_ptr_q];
	assign token_length = mem_len[rd_ptr_q];
	assign last_token   = mem_last[rd_ptr_q];

	`DTL_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, cnt_q <= CW'(dtl_pkg::Q_DEPTH))
	`DTL_ASSERT_NEXT(a_reset_after_last, clk, arst_n, in_acc && is_last, mode_q == dtl_pkg::M_IDLE && line_q == LINE_BITS'(1) && pos_q == '0)
	`DTL_ASSERT_IMPL(a_eof_kind, clk, arst_n, out_valid && last_token, token_kind == dtl_pkg::K_EOF)
	`DTL_ASSERT_NEXT(a_pop_only, clk, arst_n, pop && !in_acc, cnt_q == $past(cnt_q) - CW'(1))

endmodule

`default_nettype wire
